// ===== design/sfct_pkg.sv =====
// Package for the sensor frame CRC and temperature decoder.
// Holds frame positions, CRC-8 and scaling constants, and the shared types.
// No dependencies.
package sfct_pkg;

    localparam int TEMP_W  = 15;
    localparam int MILLI_W = 19;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // milli = (21875 * raw >> 13) - 45000
    localparam logic [14:0] SCALE_MUL   = 15'd21875;
    localparam int          SCALE_SHIFT = 13;
    localparam logic signed [MILLI_W-1:0] MILLI_OFFSET = 19'sd45000;

    // rounding divide by 10: (|milli| + 5) * ceil(2^20 / 10) >> 20
    localparam logic [17:0] ROUND_BIAS  = 18'd5;
    localparam logic [16:0] RECIP_MUL   = 17'd104858;
    localparam int          RECIP_SHIFT = 20;

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef struct packed {
        logic signed [MILLI_W-1:0] milli;
        logic                      ok;
    } scaled_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== design/sfct_byte_if.sv =====
// Channel carrying one received sensor byte per word.
// Depends on nothing.
interface sfct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== design/sfct_temp_if.sv =====
// Channel carrying one decoded frame result per word.
// Depends on nothing.
interface sfct_temp_if;
    logic              valid;
    logic              ready;
    logic signed [14:0] temperature_centi;
    logic              crc_ok;

    modport source (output valid, output temperature_centi, output crc_ok, input ready);
    modport sink   (input valid, input temperature_centi, input crc_ok, output ready);
endinterface

// ===== design/sensor_frame_crc_temp_decoder.sv =====
// Top level of the sensor frame CRC and temperature decoder.
// Depends on sfct_pkg, sfct_byte_if, sfct_temp_if, sfct_frame, sfct_scale.
//
// Takes one response byte per word on rx, one per clock when the result side
// keeps up. Bytes 0-1 are the temperature word, byte 2 its CRC-8 (poly 0x31,
// init 0xFF), bytes 3-4 humidity, byte 5 its CRC-8; frame_start forces byte 0.
// After byte 5 one word leaves on result via both stage registers: crc_ok and
// the temperature in 0.01 degC (0 when rejected). The CRC byte update and the
// scaling multiply sit in the frame stage, the divide by ten in the result
// stage; each stage holds one word, so stalls on result back up into rx.
module sensor_frame_crc_temp_decoder (
    input logic         clk,
    input logic         rst_n,
    sfct_byte_if.sink   rx,
    sfct_temp_if.source result
);

    sfct_pkg::scaled_t scaled;
    logic              scaled_valid;
    logic              scaled_ready;

    sfct_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .scaled       (scaled),
        .scaled_valid (scaled_valid),
        .scaled_ready (scaled_ready)
    );

    sfct_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .scaled       (scaled),
        .scaled_valid (scaled_valid),
        .scaled_ready (scaled_ready),
        .result       (result)
    );

endmodule

// ===== design/sfct_frame.sv =====
// Frame tracker: byte position, per-word CRC-8, raw temperature capture,
// and the milli-degree scaling register. Depends on sfct_pkg, sfct_byte_if.
module sfct_frame (
    input  logic             clk,
    input  logic             rst_n,
    sfct_byte_if.sink        rx,
    output sfct_pkg::scaled_t scaled,
    output logic             scaled_valid,
    input  logic             scaled_ready
);

    sfct_pkg::pos_t    pos_reg, pos_next, pos_cur;
    logic [7:0]        crc_reg, crc_next;
    logic [15:0]       raw_reg, raw_next;
    logic              first_good_reg, first_good_next;
    sfct_pkg::scaled_t scaled_reg, scaled_next;
    logic              valid_reg, valid_next;
    logic              accept;
    logic [30:0]       prod;
    logic [7:0]        crc_upd, crc_first;

    assign rx.ready = !valid_reg || scaled_ready;
    assign accept   = rx.valid && rx.ready;

    assign pos_cur   = (rx.frame_start || pos_reg > sfct_pkg::POS_H_CRC)
                       ? sfct_pkg::POS_T_MSB : pos_reg;
    assign crc_upd   = sfct_pkg::crc8_byte(crc_reg, rx.rx_byte);
    assign crc_first = sfct_pkg::crc8_byte(sfct_pkg::CRC_INIT, rx.rx_byte);
    assign prod      = 31'(sfct_pkg::SCALE_MUL) * 31'(raw_reg);

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        raw_next        = raw_reg;
        first_good_next = first_good_reg;
        scaled_next     = scaled_reg;
        valid_next      = valid_reg && !scaled_ready;
        if (accept)
        begin
            unique case (pos_cur)
                sfct_pkg::POS_T_MSB:
                begin
                    crc_next = crc_first;
                    raw_next = {rx.rx_byte, 8'h00};
                    pos_next = sfct_pkg::POS_T_LSB;
                end
                sfct_pkg::POS_T_LSB:
                begin
                    crc_next = crc_upd;
                    raw_next = {raw_reg[15:8], rx.rx_byte};
                    pos_next = sfct_pkg::POS_T_CRC;
                end
                sfct_pkg::POS_T_CRC:
                begin
                    first_good_next = (crc_reg == rx.rx_byte);
                    pos_next        = sfct_pkg::POS_H_MSB;
                end
                sfct_pkg::POS_H_MSB:
                begin
                    crc_next = crc_first;
                    pos_next = sfct_pkg::POS_H_LSB;
                end
                sfct_pkg::POS_H_LSB:
                begin
                    crc_next = crc_upd;
                    pos_next = sfct_pkg::POS_H_CRC;
                end
                sfct_pkg::POS_H_CRC:
                begin
                    scaled_next.ok    = first_good_reg && (crc_reg == rx.rx_byte);
                    scaled_next.milli = $signed({1'b0, prod[30:sfct_pkg::SCALE_SHIFT]})
                                        - sfct_pkg::MILLI_OFFSET;
                    valid_next        = 1'b1;
                    pos_next          = sfct_pkg::POS_T_MSB;
                end
                default:
                begin
                    pos_next = sfct_pkg::POS_T_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= sfct_pkg::POS_T_MSB;
            crc_reg        <= sfct_pkg::CRC_INIT;
            raw_reg        <= '0;
            first_good_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            raw_reg        <= raw_next;
            first_good_reg <= first_good_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign scaled       = scaled_reg;
    assign scaled_valid = valid_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sfct_pkg::POS_H_CRC)
        else $error("frame position out of range");

    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rx.frame_start |=> pos_reg == sfct_pkg::POS_T_LSB)
        else $error("frame start did not resynchronize position");

    a_scaled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        scaled_valid && !scaled_ready |=> scaled_valid && $stable(scaled))
        else $error("scaled word changed while stalled");
`endif

endmodule

// ===== design/sfct_scale.sv =====
// Rounding divide by ten of the milli-degree value and the result register.
// Depends on sfct_pkg, sfct_temp_if.
module sfct_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  sfct_pkg::scaled_t scaled,
    input  logic             scaled_valid,
    output logic             scaled_ready,
    sfct_temp_if.source      result
);

    logic                             neg;
    logic [17:0]                      mag, rounded;
    logic [34:0]                      prod;
    logic [sfct_pkg::TEMP_W-1:0]      quot;
    logic signed [sfct_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic                             ok_reg;
    logic                             valid_reg, valid_next;

    assign neg     = scaled.milli[sfct_pkg::MILLI_W-1];
    assign mag     = neg ? 18'(-scaled.milli) : 18'(scaled.milli);
    assign rounded = mag + sfct_pkg::ROUND_BIAS;
    assign prod    = 35'(rounded) * 35'(sfct_pkg::RECIP_MUL);
    assign quot    = prod[sfct_pkg::RECIP_SHIFT +: sfct_pkg::TEMP_W];

    always_comb
    begin
        if (!scaled.ok)
            temp_next = '0;
        else if (neg)
            temp_next = -$signed(quot);
        else
            temp_next = $signed(quot);
    end

    assign scaled_ready = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg && !result.ready;
        if (scaled_valid && scaled_ready)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (scaled_valid && scaled_ready)
        begin
            temp_reg <= temp_next;
            ok_reg   <= scaled.ok;
        end
    end

    assign result.valid             = valid_reg;
    assign result.temperature_centi = temp_reg;
    assign result.crc_ok            = ok_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.crc_ok |-> result.temperature_centi == '0)
        else $error("rejected frame with nonzero temperature");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.crc_ok |->
            (result.temperature_centi >= -15'sd4500 && result.temperature_centi <= 15'sd13000))
        else $error("temperature out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=>
            result.valid && $stable(result.temperature_centi) && $stable(result.crc_ok))
        else $error("result word changed while stalled");
`endif

endmodule
